### hdl/lzrd_pkg.sv
// ----------------------------------------------------------------------------
// lzrd_pkg - shared definitions for the lzss ring decoder
// Defaults, the parser state type, status codes and the result beat type.
// ----------------------------------------------------------------------------
package lzrd_pkg;

	// default geometry
	localparam int LZRD_RING_SIZE  = 4096;
	localparam int LZRD_MATCH_BIAS = 2;

	// width of the backward distance carried by a match token
	localparam int LZRD_DIST_W = 12;

	// preset content of the lower part of the ring
	localparam logic [7:0] LZRD_FILL_BYTE = 8'h20;

	// parser and copy sequencer states
	typedef enum logic [3:0] {
		S_START,
		S_FLAG,
		S_TOKEN,
		S_HIGH,
		S_REDUCE,
		S_ADDR,
		S_COPY,
		S_SUM,
		S_DONE
	} lzrd_state_t;

	// final status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_TRUNC    = 2'd2
	} lzrd_status_t;

	// one result beat as produced by the sequencer
	typedef struct packed {
		logic         valid;
		logic [7:0]   out_byte;
		logic         out_last;
		logic         status_valid;
		lzrd_status_t status;
	} lzrd_res_t;

endpackage

### hdl/lzrd_in_if.sv
// ----------------------------------------------------------------------------
// lzrd_in_if - compressed stream channel
// Carries one compressed byte or an end-of-stream mark per beat.
// ----------------------------------------------------------------------------
interface lzrd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

### hdl/lzrd_out_if.sv
// ----------------------------------------------------------------------------
// lzrd_out_if - decoded result channel
// Carries one decoded byte or the final status per beat.
// ----------------------------------------------------------------------------
interface lzrd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       status_valid;
	logic [1:0] status;

	modport source (output valid, output out_byte, output out_last, output status_valid,
		output status, input ready);
	modport sink   (input valid, input out_byte, input out_last, input status_valid,
		input status, output ready);
endinterface

### hdl/lzss_ring_decoder_core.sv
// ----------------------------------------------------------------------------
// lzss_ring_decoder_core - lzss decoder with ring history and checksum
// Top level: parser and copy sequencer, history ring and result register.
// ----------------------------------------------------------------------------
// result: a result beat is registered in the cycle after the beat that causes it
// flag, literal and checksum beats: one beat per cycle while results drain
// match: distance reduction and source address, then one copied byte per cycle from the ring
//   read port while results drain; RED_STEPS is 13 - clog2(RING_SIZE) distance reduction steps
// reset: asynchronous, no clearing pass; the preset ring content is tracked
//   by a write count, so the first beat is accepted right after reset
module lzss_ring_decoder_core
	import lzrd_pkg::*;
#(
	parameter int RING_SIZE  = LZRD_RING_SIZE,
	parameter int MATCH_BIAS = LZRD_MATCH_BIAS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	lzrd_in_if.sink     stream,
	lzrd_out_if.source  result
);

	localparam int AW = $clog2(RING_SIZE);

	lzrd_res_t     res;
	logic          res_free;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          status_valid_q;
	lzrd_status_t  status_q;

	lzrd_ctrl #(
		.RING_SIZE  (RING_SIZE),
		.MATCH_BIAS (MATCH_BIAS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (stream.valid),
		.in_ready         (stream.ready),
		.in_data_byte     (stream.data_byte),
		.in_end_of_stream (stream.end_of_stream),
		.res_free         (res_free),
		.res              (res),
		.wr_en            (wr_en),
		.wr_addr          (wr_addr),
		.wr_data          (wr_data),
		.rd_en            (rd_en),
		.rd_addr          (rd_addr),
		.rd_data          (rd_data)
	);

	lzrd_ring #(
		.RING_SIZE  (RING_SIZE),
		.MATCH_BIAS (MATCH_BIAS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// result register takes a new beat when empty or being taken
	assign res_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res.valid) begin
			out_byte_q     <= res.out_byte;
			out_last_q     <= res.out_last;
			status_valid_q <= res.status_valid;
			status_q       <= res.status;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_byte     = out_byte_q;
	assign result.out_last     = out_last_q;
	assign result.status_valid = status_valid_q;
	assign result.status       = status_q;

endmodule

### hdl/lzrd_ring.sv
// ----------------------------------------------------------------------------
// lzrd_ring - history ring memory
// One write and one registered read per cycle. A write count stands in for
// the preset content, and a same-address write is forwarded to the read.
// ----------------------------------------------------------------------------
module lzrd_ring
	import lzrd_pkg::*;
#(
	parameter int RING_SIZE  = LZRD_RING_SIZE,
	parameter int MATCH_BIAS = LZRD_MATCH_BIAS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [$clog2(RING_SIZE)-1:0] wr_addr,
	input  logic [7:0]                   wr_data,
	input  logic                         rd_en,
	input  logic [$clog2(RING_SIZE)-1:0] rd_addr,
	output logic [7:0]                   rd_data
);

	localparam int AW        = $clog2(RING_SIZE);
	localparam int MAX_MATCH = 16 + MATCH_BIAS;
	localparam int FILL_END  = (RING_SIZE > MAX_MATCH) ? RING_SIZE - MAX_MATCH : 0;

	logic [7:0]  mem_q [RING_SIZE];
	logic [7:0]  rd_data_q;
	logic [7:0]  alt_q;
	logic        use_mem_q;
	logic [AW:0] fill_cnt_q;

	logic [AW:0] offs;
	logic        written;
	logic        bypass;
	logic [7:0]  preset;

	// storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// distance of the read address from the first written entry
	always_comb begin
		if ({1'b0, rd_addr} >= (AW+1)'(FILL_END)) begin
			offs = {1'b0, rd_addr} - (AW+1)'(FILL_END);
		end else begin
			offs = {1'b0, rd_addr} + (AW+1)'(RING_SIZE) - (AW+1)'(FILL_END);
		end
		written = (offs < fill_cnt_q);
		bypass  = wr_en && (wr_addr == rd_addr);
		preset  = ({1'b0, rd_addr} < (AW+1)'(FILL_END)) ? LZRD_FILL_BYTE : 8'h00;
	end

	// write count, saturating once the whole ring holds written data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			use_mem_q  <= 1'b0;
		end else begin
			if (wr_en && (fill_cnt_q != (AW+1)'(RING_SIZE))) begin
				fill_cnt_q <= fill_cnt_q + 1'b1;
			end
			if (rd_en) begin
				use_mem_q <= written && !bypass;
			end
		end
	end

	// alternate read data: forwarded write or preset content
	always_ff @(posedge clk) begin
		if (rd_en) begin
			alt_q <= bypass ? wr_data : preset;
		end
	end

	assign rd_data = use_mem_q ? rd_data_q : alt_q;

endmodule

### hdl/lzrd_ctrl.sv
// ----------------------------------------------------------------------------
// lzrd_ctrl - token parser and copy sequencer
// Parses flag, literal and match beats, reduces the distance by repeated
// subtraction, runs the byte copy loop and keeps the checksum.
// ----------------------------------------------------------------------------
module lzrd_ctrl
	import lzrd_pkg::*;
#(
	parameter int RING_SIZE  = LZRD_RING_SIZE,
	parameter int MATCH_BIAS = LZRD_MATCH_BIAS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [31:0]                  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_data_byte,
	input  logic                         in_end_of_stream,
	input  logic                         res_free,
	output lzrd_res_t                    res,
	output logic                         wr_en,
	output logic [$clog2(RING_SIZE)-1:0] wr_addr,
	output logic [7:0]                   wr_data,
	output logic                         rd_en,
	output logic [$clog2(RING_SIZE)-1:0] rd_addr,
	input  logic [7:0]                   rd_data
);

	localparam int AW        = $clog2(RING_SIZE);
	localparam int MAX_MATCH = 16 + MATCH_BIAS;
	localparam int FILL_END  = (RING_SIZE > MAX_MATCH) ? RING_SIZE - MAX_MATCH : 0;
	localparam int CW        = $clog2(MAX_MATCH + 1);
	localparam int DW        = LZRD_DIST_W + 1;
	localparam int RED_STEPS = LZRD_DIST_W + 1 - AW;
	localparam int SW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	lzrd_state_t   state_q, state_d;
	logic [31:0]   cfg_q;
	logic [31:0]   rem_q;
	logic [31:0]   sum_q;
	logic [31:0]   recv_q;
	logic [1:0]    scnt_q;
	logic [8:0]    flag_q;
	logic [7:0]    low_q;
	logic [DW-1:0] dist_q;
	logic [SW-1:0] step_q;
	logic [CW-1:0] len_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] src_q;
	logic          rdv_q;

	logic          accept;
	logic          byte_emit;
	logic          copy_emit;
	logic          issue;
	logic          tok_done;
	logic [8:0]    flag_shr;
	logic [31:0]   rem_dec;
	lzrd_state_t   fin_state;
	logic [31:0]   recv_new;
	logic [CW-1:0] count;
	logic [DW-1:0] ring_shl;
	logic [AW:0]   src_sub;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
		if (a == AW'(RING_SIZE - 1)) begin
			return '0;
		end
		return a + 1'b1;
	endfunction

	// shared terms
	always_comb begin
		flag_shr  = flag_q >> 1;
		rem_dec   = rem_q - 32'd1;
		if (rem_dec == 32'd0) begin
			fin_state = S_SUM;
		end else if (flag_shr <= 9'd1) begin
			fin_state = S_FLAG;
		end else begin
			fin_state = S_TOKEN;
		end
		recv_new  = recv_q | (32'(in_data_byte) << {scnt_q, 3'b000});
		count     = CW'(in_data_byte[3:0]) + CW'(MATCH_BIAS + 1);
		ring_shl  = DW'(RING_SIZE) << step_q;
		src_sub   = {1'b0, wp_q} - {1'b0, dist_q[AW-1:0]};
		copy_emit = rdv_q && res_free;
		issue     = (state_q == S_COPY) && (len_q != '0) && (!rdv_q || copy_emit);
	end

	// handshake, result beat and ring controls
	always_comb begin
		in_ready  = 1'b0;
		res       = '0;
		wr_en     = 1'b0;
		wr_data   = in_data_byte;
		rd_en     = issue;
		byte_emit = 1'b0;
		tok_done  = 1'b0;
		case (state_q)
			S_START, S_FLAG, S_TOKEN, S_HIGH, S_SUM: in_ready = res_free;
			S_DONE:                                  in_ready = 1'b1;
			default:                                 in_ready = 1'b0;
		endcase
		accept = in_valid && in_ready;
		case (state_q)
			S_START: begin
				if (accept && (cfg_q == 32'd0)) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = STAT_OK;
					res.out_last     = 1'b1;
				end else if (accept && in_end_of_stream) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = STAT_TRUNC;
					res.out_last     = 1'b1;
				end
			end
			S_FLAG, S_HIGH: begin
				if (accept && in_end_of_stream) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = STAT_TRUNC;
					res.out_last     = 1'b1;
				end
			end
			S_TOKEN: begin
				if (accept && in_end_of_stream) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = STAT_TRUNC;
					res.out_last     = 1'b1;
				end else if (accept && flag_q[0]) begin
					res.valid    = 1'b1;
					res.out_byte = in_data_byte;
					res.out_last = 1'b1;
					wr_en        = 1'b1;
					byte_emit    = 1'b1;
					tok_done     = 1'b1;
				end
			end
			S_COPY: begin
				if (copy_emit) begin
					res.valid    = 1'b1;
					res.out_byte = rd_data;
					res.out_last = (len_q == '0);
					wr_en        = 1'b1;
					wr_data      = rd_data;
					byte_emit    = 1'b1;
					tok_done     = (len_q == '0);
				end
			end
			S_SUM: begin
				if (accept && in_end_of_stream) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = STAT_TRUNC;
					res.out_last     = 1'b1;
				end else if (accept && (scnt_q == 2'd3)) begin
					res.valid        = 1'b1;
					res.status_valid = 1'b1;
					res.status       = (recv_new == sum_q) ? STAT_OK : STAT_MISMATCH;
					res.out_last     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = wp_q;
	assign rd_addr = src_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_START: begin
				if (accept) begin
					if ((cfg_q == 32'd0) || in_end_of_stream) begin
						state_d = S_DONE;
					end else begin
						state_d = S_TOKEN;
					end
				end
			end
			S_FLAG: begin
				if (accept) begin
					state_d = in_end_of_stream ? S_DONE : S_TOKEN;
				end
			end
			S_TOKEN: begin
				if (accept) begin
					if (in_end_of_stream) begin
						state_d = S_DONE;
					end else if (flag_q[0]) begin
						state_d = fin_state;
					end else begin
						state_d = S_HIGH;
					end
				end
			end
			S_HIGH: begin
				if (accept) begin
					state_d = in_end_of_stream ? S_DONE : S_REDUCE;
				end
			end
			S_REDUCE: begin
				if (step_q == '0) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR:  state_d = S_COPY;
			S_COPY: begin
				if (tok_done) begin
					state_d = fin_state;
				end
			end
			S_SUM: begin
				if (accept && (in_end_of_stream || (scnt_q == 2'd3))) begin
					state_d = S_DONE;
				end
			end
			S_DONE:  state_d = S_DONE;
			default: state_d = S_DONE;
		endcase
	end

	// control and model state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			cfg_q   <= '0;
			rem_q   <= '0;
			sum_q   <= '0;
			recv_q  <= '0;
			scnt_q  <= '0;
			flag_q  <= '0;
			wp_q    <= AW'(FILL_END % RING_SIZE);
			rdv_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if ((state_q == S_START) && accept) begin
				rem_q <= cfg_q;
			end
			// flag byte, either first after start or announced by the shift
			if (accept && !in_end_of_stream &&
				(((state_q == S_START) && (cfg_q != 32'd0)) || (state_q == S_FLAG))) begin
				flag_q <= {1'b1, in_data_byte};
			end else if (tok_done) begin
				flag_q <= flag_shr;
			end
			// emitted byte: checksum, count and ring position
			if (byte_emit) begin
				sum_q <= sum_q + 32'(res.out_byte);
				rem_q <= rem_dec;
				wp_q  <= ring_inc(wp_q);
			end
			// trailing checksum bytes
			if ((state_q == S_SUM) && accept && !in_end_of_stream) begin
				recv_q <= recv_new;
				scnt_q <= scnt_q + 2'd1;
			end
			// read in flight
			if (issue) begin
				rdv_q <= 1'b1;
			end else if (copy_emit) begin
				rdv_q <= 1'b0;
			end
		end
	end

	// match datapath
	always_ff @(posedge clk) begin
		if ((state_q == S_TOKEN) && accept && !in_end_of_stream && !flag_q[0]) begin
			low_q <= in_data_byte;
		end
		if ((state_q == S_HIGH) && accept && !in_end_of_stream) begin
			dist_q <= {1'b0, in_data_byte[7:4], low_q};
			step_q <= SW'(RED_STEPS - 1);
			len_q  <= (rem_q < 32'(count)) ? rem_q[CW-1:0] : count;
		end
		// distance modulo ring size, one shifted subtraction per cycle
		if (state_q == S_REDUCE) begin
			if (dist_q >= ring_shl) begin
				dist_q <= dist_q - ring_shl;
			end
			if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
		// copy source behind the write position
		if (state_q == S_ADDR) begin
			if (wp_q >= dist_q[AW-1:0]) begin
				src_q <= src_sub[AW-1:0];
			end else begin
				src_q <= AW'(src_sub + (AW+1)'(RING_SIZE));
			end
		end
		if (issue) begin
			src_q <= ring_inc(src_q);
			len_q <= len_q - 1'b1;
		end
	end

endmodule

### tb/sv/lzss_ring_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// lzss_ring_decoder_core_tb - self-checking bench for the lzss ring decoder
// Drives one compressed stream through the decoder and predicts every
// decoded byte and the final status with a behavioral copy of the parser,
// ring history and checksum. It covers directed tokens, a late length write,
// an output hold-off and a random stream, and it ends with the checksum
// or a truncation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_ring_decoder_core_tb;
	import lzrd_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int FILL_END     = LZRD_RING_SIZE - (16 + LZRD_MATCH_BIAS);
	localparam int SETTLE       = 40;
	localparam int HOLD_CYCLES  = 250;
	localparam int LIMIT_CYCLES = 400000;

	// one expected result beat
	typedef struct {
		logic [7:0]   data;
		logic         last;
		logic         has_status;
		lzrd_status_t status;
	} dec_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	lzrd_in_if  stream_ch ();
	lzrd_out_if result_ch ();

	lzss_ring_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stream    (stream_ch),
		.result    (result_ch)
	);

	// decoder prediction state
	logic [7:0]   dec_ring [LZRD_RING_SIZE];
	logic [11:0]  dec_wr_pos;
	logic [8:0]   dec_flags;
	lzrd_state_t  dec_phase;
	logic [7:0]   dec_dist_lo;
	logic [31:0]  dec_left;
	logic [31:0]  dec_sum;
	logic [31:0]  dec_rx_sum;
	logic [1:0]   dec_rx_count;
	logic [31:0]  dec_length = '0;
	dec_result_t  decoded_q [$];

	int   bad_count   = 0;
	int   stall_left  = 0;
	logic gaps_on     = 1'b1;
	logic hold_active = 1'b0;
	logic offering    = 1'b0;
	event hold_go;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one decoded byte goes out, into the ring and into the sum
	function automatic void emit_decoded(input logic [7:0] v);
		dec_sum              = dec_sum + 32'(v);
		dec_ring[dec_wr_pos] = v;
		dec_wr_pos           = dec_wr_pos + 12'd1;
		dec_left             = dec_left - 32'd1;
		decoded_q.push_back('{v, 1'b0, 1'b0, STAT_OK});
	endfunction

	// consume one flag bit, pick the next parse step
	function automatic void end_token();
		dec_flags = dec_flags >> 1;
		if (dec_left == 0)
			dec_phase = S_SUM;
		else
			dec_phase = (dec_flags <= 9'd1) ? S_FLAG : S_TOKEN;
	endfunction

	// expected results of one accepted stream beat
	function automatic void decode_beat(input logic [7:0] b, input logic eos);
		int          first;
		int          count;
		logic [11:0] src;
		first = decoded_q.size();
		if (dec_phase == S_DONE)
			return;
		if (dec_phase == S_START) begin
			dec_left = dec_length;
			if (dec_left == 0) begin
				dec_phase = S_DONE;
				decoded_q.push_back('{8'h00, 1'b1, 1'b1, STAT_OK});
				return;
			end
			dec_phase = S_FLAG;
		end
		if (eos) begin
			dec_phase = S_DONE;
			decoded_q.push_back('{8'h00, 1'b1, 1'b1, STAT_TRUNC});
			return;
		end
		case (dec_phase)
			S_FLAG: begin
				dec_flags = {1'b1, b};
				dec_phase = S_TOKEN;
			end
			S_TOKEN: begin
				if (dec_flags[0]) begin
					emit_decoded(b);
					end_token();
				end else begin
					dec_dist_lo = b;
					dec_phase   = S_HIGH;
				end
			end
			S_HIGH: begin
				// byte by byte so that a copy may run over its own output
				src   = dec_wr_pos - {b[7:4], dec_dist_lo};
				count = int'(b[3:0]) + LZRD_MATCH_BIAS + 1;
				while (count > 0 && dec_left != 0) begin
					emit_decoded(dec_ring[src]);
					src   = src + 12'd1;
					count = count - 1;
				end
				end_token();
			end
			S_SUM: begin
				dec_rx_sum = dec_rx_sum | (32'(b) << (8 * int'(dec_rx_count)));
				if (dec_rx_count == 2'd3) begin
					dec_phase = S_DONE;
					decoded_q.push_back('{8'h00, 1'b0, 1'b1,
						(dec_rx_sum == dec_sum) ? STAT_OK : STAT_MISMATCH});
				end else begin
					dec_rx_count = dec_rx_count + 2'd1;
				end
			end
			default: dec_phase = S_DONE;
		endcase
		if (decoded_q.size() > first)
			decoded_q[decoded_q.size() - 1].last = 1'b1;
	endfunction

	// well-formed stream content for the current parse step
	function automatic logic [7:0] next_token_byte();
		logic [3:0] hi;
		logic [3:0] ln;
		case (dec_phase)
			S_START, S_FLAG: begin
				// near the end all matches, so the last copy overruns the length
				if (dec_phase == S_FLAG && dec_left < 48)
					return 8'h00;
				return 8'($urandom);
			end
			S_HIGH: begin
				hi = ($urandom_range(0, 1) == 1) ? 4'h0 : 4'($urandom);
				ln = (dec_left < 18) ? 4'hF : 4'($urandom);
				return {hi, ln};
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// offer one beat, hold it until accepted
	task automatic push_stream_beat(input logic [7:0] b, input logic eos);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			if (offering)
				stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		stream_ch.valid         <= 1'b1;
		stream_ch.data_byte     <= b;
		stream_ch.end_of_stream <= eos;
		offering = 1'b1;
		@(posedge clk);
		while (!stream_ch.ready)
			@(posedge clk);
		decode_beat(b, eos);
	endtask

	task automatic release_stream();
		if (offering)
			stream_ch.valid <= 1'b0;
		offering = 1'b0;
	endtask

	task automatic write_length(input logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		dec_length = v;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// all expected beats in, then room for a copy still running
	task automatic wait_drained();
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// length writes before the first beat, last one wins
	task automatic test_config_before_start();
		write_length(32'hFFFF_FFFF);
		write_length(32'h0000_0000);
		write_length(32'($urandom_range(420, 520)));
	endtask

	// literal and match extremes, overlap, distance wrap, full flag bytes
	task automatic test_directed_tokens();
		push_stream_beat(8'h55, 1'b0);
		push_stream_beat(8'h00, 1'b0);
		// distance 0, longest copy from the unfilled top of the ring
		push_stream_beat(8'h00, 1'b0);
		push_stream_beat(8'h0F, 1'b0);
		push_stream_beat(8'hFF, 1'b0);
		// distance 4095, shortest copy
		push_stream_beat(8'hFF, 1'b0);
		push_stream_beat(8'hF0, 1'b0);
		push_stream_beat(8'h41, 1'b0);
		// distance 1, copy overlaps itself
		push_stream_beat(8'h01, 1'b0);
		push_stream_beat(8'h0F, 1'b0);
		push_stream_beat(8'h80, 1'b0);
		// distance 256 wraps back into the space fill
		push_stream_beat(8'h00, 1'b0);
		push_stream_beat(8'h13, 1'b0);
		// eight literals, walking one
		push_stream_beat(8'hFF, 1'b0);
		for (int k = 0; k < 8; k++)
			push_stream_beat(8'h01 << k, 1'b0);
		release_stream();
	endtask

	// a length write mid-stream must not change the decode
	task automatic test_late_config();
		wait_drained();
		write_length(32'h0000_0000);
	endtask

	// output held off while beats keep coming
	task automatic test_backpressure();
		gaps_on = 1'b0;
		-> hold_go;
		for (int k = 0; k < 24; k++) begin
			if (dec_phase == S_SUM || dec_phase == S_DONE)
				break;
			push_stream_beat(next_token_byte(), 1'b0);
		end
	endtask

	task automatic test_random_stream();
		gaps_on = 1'b1;
		while (dec_phase != S_SUM && dec_phase != S_DONE)
			push_stream_beat(next_token_byte(), 1'b0);
	endtask

	// trailing sum: correct, corrupted, or cut short by end of stream
	task automatic test_checksum_end();
		logic [31:0] sum_word;
		int          mode;
		int          cut;
		gaps_on  = 1'b0;
		mode     = $urandom_range(0, 9);
		sum_word = dec_sum;
		if (mode >= 5)
			sum_word = sum_word ^ (32'h1 << $urandom_range(0, 31));
		cut = (mode >= 8) ? $urandom_range(0, 3) : 4;
		for (int k = 0; k < cut; k++)
			push_stream_beat(sum_word[8 * k +: 8], 1'b0);
		if (cut < 4)
			push_stream_beat(8'($urandom), 1'b1);
		release_stream();
	endtask

	// after the status nothing comes out, whatever arrives
	task automatic test_after_status();
		wait_drained();
		write_length(32'hFFFF_FFFF);
		push_stream_beat(8'h00, 1'b1);
		push_stream_beat(8'hFF, 1'b0);
		push_stream_beat(8'($urandom), 1'b0);
		push_stream_beat(8'($urandom), 1'b1);
		release_stream();
	endtask

	// result side ready with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (hold_active) begin
			result_ch.ready <= 1'b0;
		end else if (gaps_on && stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// long output hold-off, counted here
	always @(hold_go) begin
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		dec_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (decoded_q.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected beat: byte %02h last %0b status_valid %0b status %0d",
						result_ch.out_byte, result_ch.out_last, result_ch.status_valid,
						result_ch.status);
			end else begin
				want = decoded_q.pop_front();
				if (result_ch.out_byte !== want.data || result_ch.out_last !== want.last ||
					result_ch.status_valid !== want.has_status ||
					result_ch.status !== want.status) begin
					bad_count++;
					if (bad_count <= 10)
						$display("mismatch: expected byte %02h last %0b status_valid %0b %s %0d, %s %02h %0b %0b %0d",
							want.data, want.last, want.has_status, "status", want.status,
							"got", result_ch.out_byte, result_ch.out_last,
							result_ch.status_valid, result_ch.status);
				end
			end
		end
	end

	initial begin
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_wdata               <= '0;
		stream_ch.valid         <= 1'b0;
		stream_ch.data_byte     <= '0;
		stream_ch.end_of_stream <= 1'b0;
		for (int k = 0; k < LZRD_RING_SIZE; k++)
			dec_ring[k] = (k < FILL_END) ? LZRD_FILL_BYTE : 8'h00;
		dec_wr_pos   = 12'(FILL_END);
		dec_flags    = '0;
		dec_phase    = S_START;
		dec_dist_lo  = '0;
		dec_left     = '0;
		dec_sum      = '0;
		dec_rx_sum   = '0;
		dec_rx_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_config_before_start();
		test_directed_tokens();
		test_late_config();
		test_backpressure();
		test_random_stream();
		test_checksum_end();
		test_after_status();
		wait_drained();

		if (bad_count == 0 && decoded_q.size() == 0)
			$display("PASS lzss_ring_decoder_core");
		else
			$display("FAIL lzss_ring_decoder_core");
		$finish;
	end

	// run limit
	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("FAIL lzss_ring_decoder_core");
		$finish;
	end

endmodule
